FILE: hdl/fqd_pkg.sv
package fqd_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_DEL = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

FILE: hdl/fqd_ctrl.sv
module fqd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output fqd_pkg::ctrl_t ctrl
);

  fqd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fqd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl.load  = 1'b0;
    ctrl.exec  = 1'b0;
    busy       = 1'b0;
    case (state)
      fqd_pkg::ST_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = fqd_pkg::ST_EXEC;
        end
      end
      fqd_pkg::ST_EXEC: begin
        busy       = 1'b1;
        ctrl.exec  = 1'b1;
        state_next = fqd_pkg::ST_IDLE;
      end
      default: begin
        state_next = fqd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/fqd_datapath.sv
module fqd_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  fqd_pkg::ctrl_t              ctrl,
  input  logic [1:0]                  cmd,
  input  logic [fqd_pkg::DATA_W-1:0]  item_value,
  output logic                        done,
  output logic                        status,
  output logic [fqd_pkg::DATA_W-1:0]  data_out,
  output logic [fqd_pkg::CNT_W-1:0]   count_after
);

  logic [1:0]                 cmd_r;
  logic [fqd_pkg::DATA_W-1:0] val_r;
  logic [fqd_pkg::DATA_W-1:0] slots [fqd_pkg::DEPTH];
  logic [fqd_pkg::CNT_W-1:0]  fill;

  logic [fqd_pkg::DEPTH-1:0]  hit;
  logic [fqd_pkg::DEPTH-1:0]  shift_mask;
  logic                       seen;
  logic                       do_enq;
  logic                       do_shift;
  logic                       ok;
  logic [fqd_pkg::CNT_W-1:0]  fill_next;
  logic [fqd_pkg::DATA_W-1:0] data_next;

  // parallel compare over the held cells, then first match from the front
  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < fqd_pkg::DEPTH; i++) begin
      hit[i]        = (slots[i] == val_r) && (fqd_pkg::CNT_W'(i) < fill);
      shift_mask[i] = seen | hit[i];
      seen          = shift_mask[i];
    end
  end

  always_comb begin
    do_enq    = 1'b0;
    do_shift  = 1'b0;
    data_next = '0;
    case (fqd_pkg::cmd_t'(cmd_r))
      fqd_pkg::CMD_ENQ: begin
        do_enq = (val_r != '0) && (fill < fqd_pkg::CNT_W'(fqd_pkg::DEPTH));
      end
      fqd_pkg::CMD_DEQ: begin
        do_shift = (fill != '0);
        if (do_shift) begin
          data_next = slots[0];
        end
      end
      fqd_pkg::CMD_DEL: begin
        do_shift = (val_r != '0) && seen;
      end
      default: begin
      end
    endcase
    ok = do_enq | do_shift;
    if (do_enq) begin
      fill_next = fill + fqd_pkg::CNT_W'(1);
    end else if (do_shift) begin
      fill_next = fill - fqd_pkg::CNT_W'(1);
    end else begin
      fill_next = fill;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= cmd;
      val_r <= item_value;
    end
  end

  // dequeue shifts every cell; delete shifts from the first match onward
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      for (int i = 0; i < fqd_pkg::DEPTH - 1; i++) begin
        if (do_shift && (fqd_pkg::cmd_t'(cmd_r) == fqd_pkg::CMD_DEQ || shift_mask[i])) begin
          slots[i] <= slots[i+1];
        end
      end
      if (do_enq) begin
        slots[fill[fqd_pkg::IDX_W-1:0]] <= val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      done <= 1'b0;
    end else begin
      done <= ctrl.exec;
      if (ctrl.exec) begin
        fill <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      status      <= ~ok;
      data_out    <= data_next;
      count_after <= fill_next;
    end
  end

endmodule

FILE: hdl/fifo_queue_with_delete.sv
// Queue of nonzero handles with enqueue, dequeue and delete-first-match.
// A request taken while idle is latched, then executed in the EXEC state; the result and done are registered, done high
// for exactly one cycle; the receiver cannot stall it.
// A new request is taken only when idle, not while busy (latch, then parallel compare and shift).
// Reset (rst, synchronous): queue empty, controller idle, no result pending.
module fifo_queue_with_delete (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  cmd,
  input  logic [fqd_pkg::DATA_W-1:0]  item_value,
  output logic                        done,
  output logic                        status,
  output logic [fqd_pkg::DATA_W-1:0]  data_out,
  output logic [fqd_pkg::CNT_W-1:0]   count_after
);

  fqd_pkg::ctrl_t ctrl;

  fqd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  fqd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .cmd         (cmd),
    .item_value  (item_value),
    .done        (done),
    .status      (status),
    .data_out    (data_out),
    .count_after (count_after)
  );

endmodule
